/* rtl/vae_pkg.sv */
// ----------------------------------------------------------------------------
// Voice allocator package
// Shared widths, codes and the command and status types of the voice allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vae_pkg;

   localparam int OP_W    = 2;
   localparam int CH_W    = 4;
   localparam int NOTE_W  = 7;
   localparam int LEVEL_W = 17;
   localparam int COEF_W  = 16;
   localparam int STAMP_W = 40;
   localparam int STAGE_W = 3;
   localparam int KIND_W  = 2;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 6;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;

   localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
   localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
   localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
   localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
   localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;
   localparam logic [STAGE_W-1:0] ST_FADING  = 3'd5;

   localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEVEL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SILENT  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REL_ACK = 2'd3;

   localparam logic [1:0] REG_VOICES     = 2'd0;
   localparam logic [1:0] REG_FADE_COEFF = 2'd1;
   localparam logic [1:0] REG_THRESHOLD  = 2'd2;

   typedef struct packed {
      logic             start;
      logic             scan_on;
      logic             scan_rel;
      logic             rd;
      logic             mul;
      logic             wr;
      logic             commit_on;
      logic             emit_ack;
      logic             emit_silent;
      logic             last;
      logic [IDX_W-1:0] pos;
   } cmd_type;

   typedef struct packed {
      logic               out_free;
      logic [IDX_W-1:0]   n_eff;
   } status_type;

   typedef struct packed {
      logic [IDX_W-1:0]   n_eff;
      logic [COEF_W-1:0]  fade_coeff;
      logic [LEVEL_W-1:0] threshold;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/voice_allocator_with_envelopes_top.sv */
// ----------------------------------------------------------------------------
// Voice allocator with envelopes
// Polyphonic voice allocation with oldest-note stealing and per-voice ADSR.
// ----------------------------------------------------------------------------
// Note on and note off scan n voices and then load their result, where n
// is voices_in_use clamped to the range 1 to MAX_VOICES.
// A tick scans one entry per cycle up to its last sounding entry, or all
// MAX_VOICES + FADE_SLOTS entries and then gives a silent result when nothing
// sounds, and each sounding entry has its level read, multiplied and written back.
// One item is in flight at a time, and output stalls add cycles; synchronous
// active-high reset idles all voices, clears fades and counters.
`timescale 1ns / 1ps
`default_nettype none

module voice_allocator_with_envelopes_top #(
   parameter int MAX_VOICES = 32,
   parameter int FADE_SLOTS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [vae_pkg::OP_W-1:0]     req_operation,
   input  wire logic [vae_pkg::CH_W-1:0]     req_channel,
   input  wire logic [vae_pkg::NOTE_W-1:0]   req_note,
   input  wire logic [vae_pkg::LEVEL_W-1:0]  req_attack_step,
   input  wire logic [vae_pkg::COEF_W-1:0]   req_decay_coeff,
   input  wire logic [vae_pkg::LEVEL_W-1:0]  req_sustain_level,
   input  wire logic [vae_pkg::COEF_W-1:0]   req_release_coeff,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [vae_pkg::KIND_W-1:0]        rsp_kind,
   output logic [vae_pkg::IDX_W-1:0]         rsp_voice_index,
   output logic                              rsp_stolen,
   output logic [vae_pkg::STAGE_W-1:0]       rsp_stage,
   output logic [vae_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [vae_pkg::CNT_W-1:0]         rsp_active_count,
   output logic [vae_pkg::CNT_W-1:0]         rsp_released_count,
   output logic                              rsp_last,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [vae_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [vae_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [vae_pkg::DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   vae_pkg::cfg_type                  cfg;
   vae_pkg::cmd_type                  cmd;
   vae_pkg::status_type               status;
   logic [MAX_VOICES+FADE_SLOTS-1:0]  sounding;

   vae_csr #(
      .MAX_VOICES (MAX_VOICES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vae_datapath #(
      .MAX_VOICES (MAX_VOICES),
      .FADE_SLOTS (FADE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_note           (req_note),
      .req_attack_step    (req_attack_step),
      .req_decay_coeff    (req_decay_coeff),
      .req_sustain_level  (req_sustain_level),
      .req_release_coeff  (req_release_coeff),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .sounding           (sounding),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_voice_index    (rsp_voice_index),
      .rsp_stolen         (rsp_stolen),
      .rsp_stage          (rsp_stage),
      .rsp_level          (rsp_level),
      .rsp_active_count   (rsp_active_count),
      .rsp_released_count (rsp_released_count),
      .rsp_last           (rsp_last)
   );

   vae_ctrl #(
      .MAX_VOICES (MAX_VOICES),
      .FADE_SLOTS (FADE_SLOTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sounding      (sounding),
      .status        (status),
      .cmd           (cmd)
   );

endmodule

`default_nettype wire

/* rtl/vae_csr.sv */
// ----------------------------------------------------------------------------
// Voice allocator register file
// APB-style configuration registers and the clamped polyphony value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vae_csr #(
   parameter int MAX_VOICES = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [vae_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [vae_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [vae_pkg::DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output vae_pkg::cfg_type                 cfg
);

   logic [vae_pkg::IDX_W-1:0]   voices_ff, voices_in;
   logic [vae_pkg::COEF_W-1:0]  fade_coeff_ff, fade_coeff_in;
   logic [vae_pkg::LEVEL_W-1:0] threshold_ff, threshold_in;
   logic                        wr_en;
   logic [1:0]                  reg_sel;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      voices_in     = voices_ff;
      fade_coeff_in = fade_coeff_ff;
      threshold_in  = threshold_ff;
      if (wr_en) begin
         case (reg_sel)
            vae_pkg::REG_VOICES: begin
               voices_in = csr_pwdata[vae_pkg::IDX_W-1:0];
            end
            vae_pkg::REG_FADE_COEFF: begin
               fade_coeff_in = csr_pwdata[vae_pkg::COEF_W-1:0];
            end
            vae_pkg::REG_THRESHOLD: begin
               threshold_in = csr_pwdata[vae_pkg::LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voices_ff     <= 6'd16;
         fade_coeff_ff <= 16'd63847;
         threshold_ff  <= 17'd66;
      end else begin
         voices_ff     <= voices_in;
         fade_coeff_ff <= fade_coeff_in;
         threshold_ff  <= threshold_in;
      end
   end

   always_comb begin
      case (reg_sel)
         vae_pkg::REG_VOICES:     csr_prdata = 32'(voices_ff);
         vae_pkg::REG_FADE_COEFF: csr_prdata = 32'(fade_coeff_ff);
         vae_pkg::REG_THRESHOLD:  csr_prdata = 32'(threshold_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (voices_ff == '0) begin
         cfg.n_eff = 6'd1;
      end else if (voices_ff > 6'(MAX_VOICES)) begin
         cfg.n_eff = 6'(MAX_VOICES);
      end else begin
         cfg.n_eff = voices_ff;
      end
      cfg.fade_coeff = fade_coeff_ff;
      cfg.threshold  = threshold_ff;
   end

endmodule

`default_nettype wire

/* rtl/vae_datapath.sv */
// ----------------------------------------------------------------------------
// Voice allocator datapath
// Voice and fade storage, envelope arithmetic and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vae_datapath #(
   parameter int MAX_VOICES = 32,
   parameter int FADE_SLOTS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [vae_pkg::OP_W-1:0]     req_operation,
   input  wire logic [vae_pkg::CH_W-1:0]     req_channel,
   input  wire logic [vae_pkg::NOTE_W-1:0]   req_note,
   input  wire logic [vae_pkg::LEVEL_W-1:0]  req_attack_step,
   input  wire logic [vae_pkg::COEF_W-1:0]   req_decay_coeff,
   input  wire logic [vae_pkg::LEVEL_W-1:0]  req_sustain_level,
   input  wire logic [vae_pkg::COEF_W-1:0]   req_release_coeff,
   input  wire vae_pkg::cfg_type             cfg,
   input  wire vae_pkg::cmd_type             cmd,
   output vae_pkg::status_type               status,
   output logic [MAX_VOICES+FADE_SLOTS-1:0]  sounding,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [vae_pkg::KIND_W-1:0]        rsp_kind,
   output logic [vae_pkg::IDX_W-1:0]         rsp_voice_index,
   output logic                              rsp_stolen,
   output logic [vae_pkg::STAGE_W-1:0]       rsp_stage,
   output logic [vae_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [vae_pkg::CNT_W-1:0]         rsp_active_count,
   output logic [vae_pkg::CNT_W-1:0]         rsp_released_count,
   output logic                              rsp_last
);

   localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int FW = (FADE_SLOTS > 1) ? $clog2(FADE_SLOTS) : 1;
   localparam int LW = vae_pkg::LEVEL_W;
   localparam int CW = vae_pkg::COEF_W;

   logic [vae_pkg::STAGE_W-1:0] stage_ff [MAX_VOICES];
   logic [vae_pkg::CH_W-1:0]    chan_ff  [MAX_VOICES];
   logic [vae_pkg::NOTE_W-1:0]  note_ff  [MAX_VOICES];
   logic [vae_pkg::STAMP_W-1:0] stamp_ff [MAX_VOICES];
   logic [LW-1:0]               level_ff [MAX_VOICES];
   logic [LW-1:0]               att_ff   [MAX_VOICES];
   logic [CW-1:0]               dec_ff   [MAX_VOICES];
   logic [LW-1:0]               sus_ff   [MAX_VOICES];
   logic [CW-1:0]               rel_ff   [MAX_VOICES];
   logic                        fbusy_ff [FADE_SLOTS];
   logic [LW-1:0]               flevel_ff[FADE_SLOTS];

   logic [vae_pkg::STAMP_W-1:0] clock_ff;
   logic [vae_pkg::CNT_W-1:0]   count_ff, count_in;

   logic                        all_off_ff;
   logic [vae_pkg::CH_W-1:0]    in_ch_ff;
   logic [vae_pkg::NOTE_W-1:0]  in_note_ff;
   logic [LW-1:0]               in_att_ff;
   logic [CW-1:0]               in_dec_ff;
   logic [LW-1:0]               in_sus_ff;
   logic [CW-1:0]               in_rel_ff;

   logic                        idle_found_ff;
   logic [VW-1:0]               idle_idx_ff;
   logic [vae_pkg::STAMP_W-1:0] old_stamp_ff;
   logic [VW-1:0]               old_idx_ff;
   logic [LW-1:0]               old_level_ff;
   logic [vae_pkg::CNT_W-1:0]   rel_cnt_ff;

   logic                        r_fade_ff;
   logic [vae_pkg::STAGE_W-1:0] r_stage_ff;
   logic [LW-1:0]               r_level_ff;
   logic [LW-1:0]               r_att_ff;
   logic [CW-1:0]               r_dec_ff;
   logic [LW-1:0]               r_sus_ff;
   logic [CW-1:0]               r_rel_ff;
   logic [LW-1:0]               m_prod_ff;
   logic                        m_neg_ff;
   logic [LW:0]                 m_sum_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [vae_pkg::KIND_W-1:0]  rsp_kind_ff;
   logic [vae_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic                        rsp_stolen_ff;
   logic [vae_pkg::STAGE_W-1:0] rsp_stage_ff;
   logic [LW-1:0]               rsp_level_ff;
   logic [vae_pkg::CNT_W-1:0]   rsp_count_ff;
   logic [vae_pkg::CNT_W-1:0]   rsp_rel_ff;
   logic                        rsp_last_ff;

   logic [VW-1:0]               vi;
   logic [FW-1:0]               fi;
   logic                        is_fade_pos;
   logic                        held;
   logic                        rel_hit;
   logic                        older;
   logic                        free_found;
   logic [FW-1:0]               free_slot;
   logic [VW-1:0]               tgt;
   logic                        stolen;
   logic [vae_pkg::CNT_W-1:0]   cnt_a, cnt_b, cnt_on;
   logic [LW:0]                 diff;
   logic [LW-1:0]               mag;
   logic [LW-1:0]               mul_a;
   logic [CW-1:0]               mul_b;
   logic [LW+CW-1:0]            prod;
   logic [vae_pkg::STAGE_W-1:0] wr_stage;
   logic [LW-1:0]               wr_level;
   logic                        wr_down;
   logic [vae_pkg::CNT_W-1:0]   cnt_wr;
   logic                        load;

   assign vi          = cmd.pos[VW-1:0];
   assign fi          = FW'(cmd.pos - vae_pkg::IDX_W'(MAX_VOICES));
   assign is_fade_pos = cmd.pos >= vae_pkg::IDX_W'(MAX_VOICES);

   always_comb begin
      for (int i = 0; i < MAX_VOICES; i++) begin
         sounding[i] = (stage_ff[i] != vae_pkg::ST_IDLE) && (vae_pkg::IDX_W'(i) < cfg.n_eff);
      end
      for (int s = 0; s < FADE_SLOTS; s++) begin
         sounding[MAX_VOICES+s] = fbusy_ff[s];
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = 0; s < FADE_SLOTS; s++) begin
         if (!free_found && !fbusy_ff[s]) begin
            free_found = 1'b1;
            free_slot  = FW'(s);
         end
      end
   end

   assign held = (stage_ff[vi] == vae_pkg::ST_ATTACK) || (stage_ff[vi] == vae_pkg::ST_DECAY) ||
                 (stage_ff[vi] == vae_pkg::ST_SUSTAIN);
   assign rel_hit = held && (all_off_ff || (chan_ff[vi] == in_ch_ff && note_ff[vi] == in_note_ff));
   assign older   = (cmd.pos == '0) || (stamp_ff[vi] < old_stamp_ff);

   assign tgt    = idle_found_ff ? idle_idx_ff : old_idx_ff;
   assign stolen = !idle_found_ff;

   always_comb begin
      cnt_a = count_ff + vae_pkg::CNT_W'(stolen && free_found);
      if (stolen) begin
         cnt_b = (cnt_a != '0) ? cnt_a - 6'd1 : cnt_a;
      end else begin
         cnt_b = cnt_a;
      end
      cnt_on = cnt_b + 6'd1;
   end

   always_comb begin
      diff = {1'b0, r_level_ff} - {1'b0, r_sus_ff};
      mag  = diff[LW] ? LW'(-diff) : diff[LW-1:0];
      if (r_fade_ff) begin
         mul_a = r_level_ff;
         mul_b = cfg.fade_coeff;
      end else if (r_stage_ff == vae_pkg::ST_DECAY) begin
         mul_a = mag;
         mul_b = r_dec_ff;
      end else begin
         mul_a = r_level_ff;
         mul_b = r_rel_ff;
      end
      prod = (LW+CW)'(mul_a) * (LW+CW)'(mul_b);
   end

   always_comb begin
      wr_stage = r_stage_ff;
      wr_level = r_level_ff;
      wr_down  = 1'b0;
      if (r_fade_ff) begin
         if (m_prod_ff <= cfg.threshold) begin
            wr_stage = vae_pkg::ST_IDLE;
            wr_level = '0;
            wr_down  = 1'b1;
         end else begin
            wr_stage = vae_pkg::ST_FADING;
            wr_level = m_prod_ff;
         end
      end else begin
         case (r_stage_ff)
            vae_pkg::ST_ATTACK: begin
               if (m_sum_ff >= {1'b0, vae_pkg::FULL_LEVEL}) begin
                  wr_stage = vae_pkg::ST_DECAY;
                  wr_level = vae_pkg::FULL_LEVEL;
               end else begin
                  wr_level = m_sum_ff[LW-1:0];
               end
            end
            vae_pkg::ST_DECAY: begin
               if (m_prod_ff < cfg.threshold) begin
                  wr_stage = vae_pkg::ST_SUSTAIN;
                  wr_level = r_sus_ff;
               end else if (m_neg_ff) begin
                  wr_level = r_sus_ff - m_prod_ff;
               end else begin
                  wr_level = r_sus_ff + m_prod_ff;
               end
            end
            vae_pkg::ST_RELEASE: begin
               if (m_prod_ff <= cfg.threshold) begin
                  wr_stage = vae_pkg::ST_IDLE;
                  wr_level = '0;
                  wr_down  = 1'b1;
               end else begin
                  wr_level = m_prod_ff;
               end
            end
            default: begin
            end
         endcase
      end
      cnt_wr = (wr_down && count_ff != '0) ? count_ff - 6'd1 : count_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit_on) begin
         count_in = cnt_on;
      end else if (cmd.wr) begin
         count_in = cnt_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            stage_ff[i] <= vae_pkg::ST_IDLE;
         end
         for (int s = 0; s < FADE_SLOTS; s++) begin
            fbusy_ff[s] <= 1'b0;
         end
         clock_ff      <= '0;
         count_ff      <= '0;
         idle_found_ff <= 1'b0;
         rel_cnt_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.start) begin
            idle_found_ff <= 1'b0;
            rel_cnt_ff    <= '0;
         end
         if (cmd.scan_on && !idle_found_ff && stage_ff[vi] == vae_pkg::ST_IDLE) begin
            idle_found_ff <= 1'b1;
         end
         if (cmd.scan_rel && rel_hit) begin
            stage_ff[vi] <= vae_pkg::ST_RELEASE;
            rel_cnt_ff   <= rel_cnt_ff + 6'd1;
         end
         if (cmd.commit_on) begin
            stage_ff[tgt] <= vae_pkg::ST_ATTACK;
            clock_ff      <= clock_ff + 40'd1;
            if (stolen) begin
               fbusy_ff[free_found ? free_slot : FW'(0)] <= 1'b1;
            end
         end
         if (cmd.wr) begin
            if (is_fade_pos) begin
               fbusy_ff[fi] <= !wr_down;
            end else begin
               stage_ff[vi] <= wr_stage;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         all_off_ff <= (req_operation == vae_pkg::OP_ALL_OFF);
         in_ch_ff   <= req_channel;
         in_note_ff <= req_note;
         in_att_ff  <= req_attack_step;
         in_dec_ff  <= req_decay_coeff;
         in_sus_ff  <= (req_sustain_level > vae_pkg::FULL_LEVEL) ? vae_pkg::FULL_LEVEL
                                                                  : req_sustain_level;
         in_rel_ff  <= req_release_coeff;
      end
      if (cmd.scan_on) begin
         if (!idle_found_ff && stage_ff[vi] == vae_pkg::ST_IDLE) begin
            idle_idx_ff <= vi;
         end
         if (older) begin
            old_stamp_ff <= stamp_ff[vi];
            old_idx_ff   <= vi;
            old_level_ff <= level_ff[vi];
         end
      end
      if (cmd.commit_on) begin
         chan_ff[tgt]  <= in_ch_ff;
         note_ff[tgt]  <= in_note_ff;
         att_ff[tgt]   <= in_att_ff;
         dec_ff[tgt]   <= in_dec_ff;
         sus_ff[tgt]   <= in_sus_ff;
         rel_ff[tgt]   <= in_rel_ff;
         level_ff[tgt] <= '0;
         stamp_ff[tgt] <= clock_ff + 40'd1;
         if (stolen) begin
            flevel_ff[free_found ? free_slot : FW'(0)] <= old_level_ff;
         end
      end
      if (cmd.rd) begin
         r_fade_ff <= is_fade_pos;
         if (is_fade_pos) begin
            r_stage_ff <= vae_pkg::ST_FADING;
            r_level_ff <= flevel_ff[fi];
         end else begin
            r_stage_ff <= stage_ff[vi];
            r_level_ff <= level_ff[vi];
         end
         r_att_ff <= att_ff[vi];
         r_dec_ff <= dec_ff[vi];
         r_sus_ff <= sus_ff[vi];
         r_rel_ff <= rel_ff[vi];
      end
      if (cmd.mul) begin
         m_prod_ff <= prod[LW+CW-1:CW];
         m_neg_ff  <= diff[LW];
         m_sum_ff  <= {1'b0, r_level_ff} + {1'b0, r_att_ff};
      end
      if (cmd.wr) begin
         if (is_fade_pos) begin
            flevel_ff[fi] <= wr_level;
         end else begin
            level_ff[vi] <= wr_level;
         end
      end
   end

   assign load = cmd.wr || cmd.commit_on || cmd.emit_ack || cmd.emit_silent;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_idx_ff    <= '0;
         rsp_stolen_ff <= 1'b0;
         rsp_stage_ff  <= vae_pkg::ST_IDLE;
         rsp_level_ff  <= '0;
         rsp_count_ff  <= count_ff;
         rsp_rel_ff    <= '0;
         rsp_last_ff   <= 1'b1;
         if (cmd.commit_on) begin
            rsp_kind_ff   <= vae_pkg::KIND_ASSIGN;
            rsp_idx_ff    <= vae_pkg::IDX_W'(tgt);
            rsp_stolen_ff <= stolen;
            rsp_stage_ff  <= vae_pkg::ST_ATTACK;
            rsp_count_ff  <= cnt_on;
         end else if (cmd.emit_ack) begin
            rsp_kind_ff <= vae_pkg::KIND_REL_ACK;
            rsp_rel_ff  <= rel_cnt_ff;
         end else if (cmd.emit_silent) begin
            rsp_kind_ff <= vae_pkg::KIND_SILENT;
         end else begin
            rsp_kind_ff  <= vae_pkg::KIND_LEVEL;
            rsp_idx_ff   <= cmd.pos;
            rsp_stage_ff <= wr_stage;
            rsp_level_ff <= wr_level;
            rsp_count_ff <= cnt_wr;
            rsp_last_ff  <= cmd.last;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.n_eff    = cfg.n_eff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_voice_index    = rsp_idx_ff;
   assign rsp_stolen         = rsp_stolen_ff;
   assign rsp_stage          = rsp_stage_ff;
   assign rsp_level          = rsp_level_ff;
   assign rsp_active_count   = rsp_count_ff;
   assign rsp_released_count = rsp_rel_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/vae_ctrl.sv */
// ----------------------------------------------------------------------------
// Voice allocator controller
// Sequences voice scans, envelope steps and result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vae_ctrl #(
   parameter int MAX_VOICES = 32,
   parameter int FADE_SLOTS = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic [vae_pkg::OP_W-1:0]         req_operation,
   output logic                                  req_stall,
   input  wire logic [MAX_VOICES+FADE_SLOTS-1:0] sounding,
   input  wire vae_pkg::status_type              status,
   output vae_pkg::cmd_type                      cmd
);

   localparam int TOTAL = MAX_VOICES + FADE_SLOTS;
   localparam int PW    = $clog2(TOTAL);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ON_SCAN,
      S_ON_COMMIT,
      S_REL_SCAN,
      S_REL_ACK,
      S_TK_SCAN,
      S_TK_RD,
      S_TK_MUL,
      S_TK_WR,
      S_TK_SILENT
   } state_type;

   state_type         state_ff, state_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [TOTAL-1:0]  mask_ff, mask_in;
   logic              emitted_ff, emitted_in;
   logic [TOTAL-1:0]  rest;
   logic              at_last_voice;
   logic              accept;

   assign accept        = req_valid && !req_stall;
   assign req_stall     = (state_ff != S_IDLE);
   assign at_last_voice = (vae_pkg::IDX_W'(pos_ff) + 6'd1) == status.n_eff;
   assign rest          = mask_ff & ~(TOTAL'(1) << pos_ff);

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      mask_in    = mask_ff;
      emitted_in = emitted_ff;
      cmd        = '0;
      cmd.pos    = vae_pkg::IDX_W'(pos_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               pos_in    = '0;
               case (req_operation)
                  vae_pkg::OP_NOTE_ON: state_in = S_ON_SCAN;
                  vae_pkg::OP_NOTE_OFF, vae_pkg::OP_ALL_OFF: state_in = S_REL_SCAN;
                  default: begin
                     mask_in    = sounding;
                     emitted_in = 1'b0;
                     state_in   = S_TK_SCAN;
                  end
               endcase
            end
         end
         S_ON_SCAN: begin
            cmd.scan_on = 1'b1;
            if (at_last_voice) begin
               state_in = S_ON_COMMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_ON_COMMIT: begin
            if (status.out_free) begin
               cmd.commit_on = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_REL_SCAN: begin
            cmd.scan_rel = 1'b1;
            if (at_last_voice) begin
               state_in = S_REL_ACK;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_REL_ACK: begin
            if (status.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TK_SCAN: begin
            if (mask_ff[pos_ff]) begin
               state_in = S_TK_RD;
            end else if (pos_ff == PW'(TOTAL - 1)) begin
               state_in = emitted_ff ? S_IDLE : S_TK_SILENT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_TK_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_TK_MUL;
         end
         S_TK_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_TK_WR;
         end
         S_TK_WR: begin
            if (status.out_free) begin
               cmd.wr     = 1'b1;
               cmd.last   = (rest == '0);
               mask_in    = rest;
               emitted_in = 1'b1;
               if (rest == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_TK_SCAN;
               end
            end
         end
         S_TK_SILENT: begin
            if (status.out_free) begin
               cmd.emit_silent = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= '0;
         mask_ff    <= '0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         mask_ff    <= mask_in;
         emitted_ff <= emitted_in;
      end
   end

   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr || cmd.commit_on || cmd.emit_ack || cmd.emit_silent) |-> status.out_free)
      else $error("Result issued while the output register is occupied.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("Controller did not leave idle after an accepted transfer.");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ON_SCAN || state_ff == S_REL_SCAN) |->
      (vae_pkg::IDX_W'(pos_ff) < status.n_eff))
      else $error("Voice scan ran past the voices in use.");

   a_last_clears_mask: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr && cmd.last) |=> (mask_ff == '0 && state_ff == S_IDLE))
      else $error("Tick ended with entries still pending.");

endmodule

`default_nettype wire
